>>> rtl/quadrotor_cascaded_pid_mixer_assert.svh
// Assertion macros used by the checker file.
`ifndef QUADROTOR_CASCADED_PID_MIXER_ASSERT_SVH
`define QUADROTOR_CASCADED_PID_MIXER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define QCPM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define QCPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/qcpm_pkg.sv
package qcpm_pkg;

   localparam int QCPM_FRAC_BITS = 16;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_OUTER,
      ST_OUTER_WAIT,
      ST_ERR,
      ST_DIFF,
      ST_INNER,
      ST_INNER_WAIT,
      ST_MIX,
      ST_OUT
   } qcpm_state_type;

   // accumulator targets
   typedef enum logic [2:0] {
      ACC_UP,
      ACC_UR,
      ACC_ROLL,
      ACC_PITCH,
      ACC_HEIGHT
   } qcpm_acc_type;

   localparam int NUM_ACC = 5;

   typedef struct packed {
      qcpm_acc_type acc;
      logic         sub;
   } qcpm_mac_op_type;

   // multiply steps
   localparam logic [3:0] STEP_OUTER_LAST = 4'd5;
   localparam logic [3:0] STEP_INNER_LAST = 4'd15;

   // register indexes
   localparam logic [2:0] REG_POS_KP   = 3'd0;
   localparam logic [2:0] REG_POS_KD   = 3'd1;
   localparam logic [2:0] REG_ATT_KP   = 3'd2;
   localparam logic [2:0] REG_ATT_KD   = 3'd3;
   localparam logic [2:0] REG_ATT_KDD  = 3'd4;
   localparam logic [2:0] REG_ALT_KP   = 3'd5;
   localparam logic [2:0] REG_ALT_KD   = 3'd6;
   localparam logic [2:0] REG_NOMINAL  = 3'd7;

   // where each product step lands and with which sign
   function automatic qcpm_mac_op_type mac_op(input logic [3:0] step);
      qcpm_mac_op_type op;
      op.sub = 1'b0;
      case (step)
         4'd0, 4'd1, 4'd2:   op.acc = ACC_UP;
         4'd3:               op.acc = ACC_UR;
         4'd4, 4'd5: begin
            op.acc = ACC_UR;
            op.sub = 1'b1;
         end
         4'd6, 4'd7, 4'd8:   op.acc = ACC_ROLL;
         4'd9, 4'd10, 4'd11: op.acc = ACC_PITCH;
         default:            op.acc = ACC_HEIGHT;
      endcase
      return op;
   endfunction

   function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] v,
                                                    input logic signed [31:0] lim);
      logic signed [31:0] r;
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [23:0] clamp_motor(input logic signed [31:0] v,
                                               input logic signed [63:0] top);
      logic signed [63:0] vx;
      logic signed [63:0] r;
      vx = 64'(v);
      if (vx > top) begin
         r = top;
      end else if (vx < 64'sd0) begin
         r = 64'sd0;
      end else begin
         r = vx;
      end
      return r[23:0];
   endfunction

endpackage

>>> rtl/quadrotor_cascaded_pid_mixer.sv
// Cascaded position/attitude PID controller with a four-motor mixer.
// req channel: one request per sensor sample, req_tdata packs six signed
// fixed-point words (roll, pitch, yaw, height, x, y), roll in the lowest bits.
// rsp channel: one result per request, rsp_tdata packs four 24-bit motor
// commands clamped to 0..255, motor one in the lowest bits.
// csr port: APB-style, eight gain/thrust registers at byte address 4*index,
// written on psel & penable & pwrite; pready is tied high. Write only while
// no request is in flight.
// Datapath: all sixteen products go through one 32x32 multiplier, one per
// cycle, and req_tready is low from acceptance until the result enters the
// output register. A new request can be taken in the cycle the result first
// shows on rsp_tdata; a request never starts before the last one finishes.
// If the receiver stalls, the result holds in the output register; the
// next request still runs and waits at the end until the register frees.
// Reset clears the loop history and loads the default gains.
module quadrotor_cascaded_pid_mixer #(
   parameter int FRAC_BITS = qcpm_pkg::QCPM_FRAC_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // roll_meas, pitch_meas, yaw_meas, height_meas, pos_x_meas, pos_y_meas
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // motor_one, motor_two, motor_three, motor_four
   output logic [95:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import qcpm_pkg::*;

   localparam longint ONE = longint'(1) << FRAC_BITS;
   localparam logic signed [31:0] ONE_W   = 32'(ONE);
   localparam logic signed [31:0] POS_KI  = 32'(ONE / 100000);
   localparam logic signed [31:0] ALT_KI  = 32'(ONE / 200);
   localparam logic signed [31:0] ALT_KDD = 32'(10 * ONE);
   localparam logic signed [31:0] RAD_SAT = 32'(3 * ONE / 200);
   localparam logic signed [31:0] U_SAT   = 32'(ONE / 2);
   localparam logic signed [63:0] MOTOR_TOP = 64'(255 * ONE);

   localparam logic [30:0] POS_KP_RST  = 31'(ONE / 10);
   localparam logic [30:0] POS_KD_RST  = 31'(5 * ONE / 2);
   localparam logic [30:0] ATT_KP_RST  = 31'(10 * ONE);
   localparam logic [30:0] ATT_KD_RST  = 31'(10 * ONE);
   localparam logic [30:0] ATT_KDD_RST = 31'(100 * ONE);
   localparam logic [30:0] ALT_KP_RST  = 31'(10 * ONE);
   localparam logic [30:0] ALT_KD_RST  = 31'(1000 * ONE);
   localparam logic [23:0] NOMINAL_RST = 24'(135 * ONE);

   // configuration
   logic [30:0] pos_kp_ff, pos_kd_ff, att_kp_ff, att_kd_ff, att_kdd_ff;
   logic [30:0] alt_kp_ff, alt_kd_ff;
   logic [23:0] nominal_ff;
   logic        csr_wr;

   // sequencer and datapath
   qcpm_state_type     state_ff, state_in;
   logic [3:0]         step_ff, step_in;
   logic signed [31:0] meas_ff [6];
   logic signed [31:0] meas_in [6];
   logic signed [31:0] pos_sum_ff [2];
   logic signed [31:0] pos_sum_in [2];
   logic signed [31:0] pos_prev_ff [2];
   logic signed [31:0] pos_prev_in [2];
   logic signed [31:0] pos_d_ff [2];
   logic signed [31:0] pos_d_in [2];
   logic signed [31:0] ax_sum_ff [4];
   logic signed [31:0] ax_sum_in [4];
   logic signed [31:0] ax_prev_ff [4];
   logic signed [31:0] ax_prev_in [4];
   logic signed [31:0] ax_prev2_ff [4];
   logic signed [31:0] ax_prev2_in [4];
   logic signed [31:0] err_ff [4];
   logic signed [31:0] err_in [4];
   logic signed [31:0] d1_ff [4];
   logic signed [31:0] d1_in [4];
   logic signed [31:0] d2_ff [4];
   logic signed [31:0] d2_in [4];
   logic signed [31:0] acc_ff [NUM_ACC];
   logic signed [31:0] acc_in [NUM_ACC];
   logic signed [31:0] mix_ff [4];
   logic signed [31:0] mix_in [4];
   logic signed [63:0] prod_ff, prod_in;
   logic               mac_valid_ff, mac_valid_in;
   logic [3:0]         mac_step_ff, mac_step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [95:0]        rsp_data_ff, rsp_data_in;

   logic signed [31:0] a_op, b_op, neg_pos_kd, fx_term;
   logic signed [31:0] u_roll, u_pitch, u_yaw, u_lift;
   qcpm_mac_op_type    mac;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_kp_ff  <= POS_KP_RST;
         pos_kd_ff  <= POS_KD_RST;
         att_kp_ff  <= ATT_KP_RST;
         att_kd_ff  <= ATT_KD_RST;
         att_kdd_ff <= ATT_KDD_RST;
         alt_kp_ff  <= ALT_KP_RST;
         alt_kd_ff  <= ALT_KD_RST;
         nominal_ff <= NOMINAL_RST;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_POS_KP:  pos_kp_ff  <= csr_pwdata[30:0];
            REG_POS_KD:  pos_kd_ff  <= csr_pwdata[30:0];
            REG_ATT_KP:  att_kp_ff  <= csr_pwdata[30:0];
            REG_ATT_KD:  att_kd_ff  <= csr_pwdata[30:0];
            REG_ATT_KDD: att_kdd_ff <= csr_pwdata[30:0];
            REG_ALT_KP:  alt_kp_ff  <= csr_pwdata[30:0];
            REG_ALT_KD:  alt_kd_ff  <= csr_pwdata[30:0];
            REG_NOMINAL: nominal_ff <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_POS_KP:  csr_prdata = {1'b0, pos_kp_ff};
         REG_POS_KD:  csr_prdata = {1'b0, pos_kd_ff};
         REG_ATT_KP:  csr_prdata = {1'b0, att_kp_ff};
         REG_ATT_KD:  csr_prdata = {1'b0, att_kd_ff};
         REG_ATT_KDD: csr_prdata = {1'b0, att_kdd_ff};
         REG_ALT_KP:  csr_prdata = {1'b0, alt_kp_ff};
         REG_ALT_KD:  csr_prdata = {1'b0, alt_kd_ff};
         REG_NOMINAL: csr_prdata = {8'd0, nominal_ff};
         default:     csr_prdata = 32'd0;
      endcase
   end

   // shared multiplier operand select
   assign neg_pos_kd = 32'sd0 - $signed({1'b0, pos_kd_ff});

   always_comb begin
      case (step_ff)
         4'd0: begin a_op = $signed({1'b0, pos_kd_ff});  b_op = pos_d_ff[0];    end
         4'd1: begin a_op = $signed({1'b0, pos_kp_ff});  b_op = pos_prev_ff[0]; end
         4'd2: begin a_op = POS_KI;                      b_op = pos_sum_ff[0];  end
         4'd3: begin a_op = neg_pos_kd;                  b_op = pos_d_ff[1];    end
         4'd4: begin a_op = $signed({1'b0, pos_kp_ff});  b_op = pos_prev_ff[1]; end
         4'd5: begin a_op = POS_KI;                      b_op = pos_sum_ff[1];  end
         4'd6: begin a_op = $signed({1'b0, att_kdd_ff}); b_op = d2_ff[0];       end
         4'd7: begin a_op = $signed({1'b0, att_kd_ff});  b_op = d1_ff[0];       end
         4'd8: begin a_op = $signed({1'b0, att_kp_ff});  b_op = err_ff[0];      end
         4'd9: begin a_op = $signed({1'b0, att_kdd_ff}); b_op = d2_ff[1];       end
         4'd10: begin a_op = $signed({1'b0, att_kd_ff}); b_op = d1_ff[1];       end
         4'd11: begin a_op = $signed({1'b0, att_kp_ff}); b_op = err_ff[1];      end
         4'd12: begin a_op = ALT_KDD;                    b_op = d2_ff[3];       end
         4'd13: begin a_op = $signed({1'b0, alt_kd_ff}); b_op = d1_ff[3];       end
         4'd14: begin a_op = $signed({1'b0, alt_kp_ff}); b_op = err_ff[3];      end
         default: begin a_op = ALT_KI;                   b_op = ax_sum_ff[3];   end
      endcase
   end

   // floor(product / 2^FRAC_BITS), low 32 bits
   assign fx_term = prod_ff[FRAC_BITS+31:FRAC_BITS];
   assign mac     = mac_op(mac_step_ff);

   assign u_roll  = clamp_sym(acc_ff[ACC_ROLL], U_SAT);
   assign u_pitch = clamp_sym(acc_ff[ACC_PITCH], U_SAT);
   assign u_yaw   = d1_ff[2] + err_ff[2];
   assign u_lift  = acc_ff[ACC_HEIGHT];

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      mac_valid_in = 1'b0;
      mac_step_in  = mac_step_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      for (int i = 0; i < 6; i++) meas_in[i] = meas_ff[i];
      for (int i = 0; i < 2; i++) begin
         pos_sum_in[i]  = pos_sum_ff[i];
         pos_prev_in[i] = pos_prev_ff[i];
         pos_d_in[i]    = pos_d_ff[i];
      end
      for (int i = 0; i < 4; i++) begin
         ax_sum_in[i]   = ax_sum_ff[i];
         ax_prev_in[i]  = ax_prev_ff[i];
         ax_prev2_in[i] = ax_prev2_ff[i];
         err_in[i]      = err_ff[i];
         d1_in[i]       = d1_ff[i];
         d2_in[i]       = d2_ff[i];
         mix_in[i]      = mix_ff[i];
      end
      for (int i = 0; i < NUM_ACC; i++) acc_in[i] = acc_ff[i];

      // accumulate the product issued in the previous cycle
      if (mac_valid_ff) begin
         if (mac.sub) begin
            acc_in[mac.acc] = acc_ff[mac.acc] - fx_term;
         end else begin
            acc_in[mac.acc] = acc_ff[mac.acc] + fx_term;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               for (int i = 0; i < 6; i++) meas_in[i] = req_tdata[32*i +: 32];
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            for (int i = 0; i < 2; i++) begin
               pos_prev_in[i] = 32'sd0 - meas_ff[4+i];
               pos_sum_in[i]  = pos_sum_ff[i] - meas_ff[4+i];
               pos_d_in[i]    = 32'sd0 - meas_ff[4+i] - pos_prev_ff[i];
            end
            for (int i = 0; i < NUM_ACC; i++) acc_in[i] = 32'sd0;
            acc_in[ACC_HEIGHT] = $signed({8'd0, nominal_ff});
            step_in  = 4'd0;
            state_in = ST_OUTER;
         end
         ST_OUTER, ST_INNER: begin
            prod_in      = a_op * b_op;
            mac_valid_in = 1'b1;
            mac_step_in  = step_ff;
            step_in      = 4'(step_ff + 4'd1);
            if (step_ff == STEP_OUTER_LAST) begin
               state_in = ST_OUTER_WAIT;
            end else if (step_ff == STEP_INNER_LAST) begin
               state_in = ST_INNER_WAIT;
            end
         end
         ST_OUTER_WAIT: begin
            state_in = ST_ERR;
         end
         ST_ERR: begin
            err_in[0] = clamp_sym(acc_ff[ACC_UR], RAD_SAT) - meas_ff[0];
            err_in[1] = clamp_sym(acc_ff[ACC_UP], RAD_SAT) - meas_ff[1];
            err_in[2] = 32'sd0 - meas_ff[2];
            err_in[3] = ONE_W - meas_ff[3];
            state_in  = ST_DIFF;
         end
         ST_DIFF: begin
            for (int i = 0; i < 4; i++) begin
               ax_sum_in[i]   = ax_sum_ff[i] + err_ff[i];
               d1_in[i]       = err_ff[i] - ax_prev_ff[i];
               d2_in[i]       = err_ff[i] - (ax_prev_ff[i] <<< 1) + ax_prev2_ff[i];
               ax_prev2_in[i] = ax_prev_ff[i];
               ax_prev_in[i]  = err_ff[i];
            end
            state_in = ST_INNER;
         end
         ST_INNER_WAIT: begin
            state_in = ST_MIX;
         end
         ST_MIX: begin
            mix_in[0] = u_lift + u_yaw - u_pitch;
            mix_in[1] = u_lift - u_yaw - u_roll;
            mix_in[2] = u_lift + u_yaw + u_pitch;
            mix_in[3] = u_lift - u_yaw + u_roll;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               for (int i = 0; i < 4; i++) begin
                  rsp_data_in[24*i +: 24] = clamp_motor(mix_ff[i], MOTOR_TOP);
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mac_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            pos_sum_ff[i]  <= 32'sd0;
            pos_prev_ff[i] <= 32'sd0;
         end
         for (int i = 0; i < 4; i++) begin
            ax_sum_ff[i]   <= 32'sd0;
            ax_prev_ff[i]  <= 32'sd0;
            ax_prev2_ff[i] <= 32'sd0;
         end
      end else begin
         state_ff     <= state_in;
         mac_valid_ff <= mac_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 2; i++) begin
            pos_sum_ff[i]  <= pos_sum_in[i];
            pos_prev_ff[i] <= pos_prev_in[i];
         end
         for (int i = 0; i < 4; i++) begin
            ax_sum_ff[i]   <= ax_sum_in[i];
            ax_prev_ff[i]  <= ax_prev_in[i];
            ax_prev2_ff[i] <= ax_prev2_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      prod_ff     <= prod_in;
      mac_step_ff <= mac_step_in;
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < 6; i++) meas_ff[i] <= meas_in[i];
      for (int i = 0; i < 2; i++) pos_d_ff[i] <= pos_d_in[i];
      for (int i = 0; i < 4; i++) begin
         err_ff[i] <= err_in[i];
         d1_ff[i]  <= d1_in[i];
         d2_ff[i]  <= d2_in[i];
         mix_ff[i] <= mix_in[i];
      end
      for (int i = 0; i < NUM_ACC; i++) acc_ff[i] <= acc_in[i];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/qcpm_checker.sv
`include "quadrotor_cascaded_pid_mixer_assert.svh"

module qcpm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);

   // stalled result holds
   `QCPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp changed while stalled")

   // one request at a time: busy right after a request is taken
   `QCPM_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while busy")

   // a result never follows its request in the very next cycle
   `QCPM_ASSERT_SAME(a_no_early_rsp, clock, reset, $rose(rsp_tvalid), !$past(req_tvalid && req_tready), "result too early")

endmodule

bind quadrotor_cascaded_pid_mixer qcpm_checker u_qcpm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
   import qcpm_pkg::*;

   typedef struct packed {
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_x;
      logic signed [31:0] height;
      logic signed [31:0] yaw;
      logic signed [31:0] pitch;
      logic signed [31:0] roll;
   } sensor_sample_type;

   typedef struct packed {
      logic [23:0] motor_four;
      logic [23:0] motor_three;
      logic [23:0] motor_two;
      logic [23:0] motor_one;
   } motor_cmd_type;

   typedef struct packed {
      logic              check;
      motor_cmd_type     motors;
      sensor_sample_type sample;
   } directed_row_type;

   typedef enum int {
      GAINS_DEFAULT,
      GAINS_RANDOM,
      GAINS_MAX,
      GAINS_ZERO,
      GAINS_MODEST
   } gain_set_type;

   localparam int FB = QCPM_FRAC_BITS;
   localparam int ONE = 1 << FB;
   localparam logic signed [31:0] RAD_SAT   = 32'(3 * ONE / 200);
   localparam logic signed [31:0] U_SAT     = 32'(ONE / 2);
   localparam logic signed [31:0] MOTOR_TOP = 32'(255 * ONE);
   localparam logic signed [31:0] POS_KI    = 32'(ONE / 100000);
   localparam logic signed [31:0] ALT_KI    = 32'(ONE / 200);
   localparam logic signed [31:0] ALT_KDD   = 32'(10 * ONE);

   localparam logic [31:0] Q_ONE  = 32'h0001_0000;
   localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN  = 32'h8000_0000;
   localparam logic [31:0] Q_NEG1 = 32'hFFFF_FFFF;
   localparam logic [31:0] Q_ZERO = 32'h0000_0000;

   localparam motor_cmd_type HOVER_CMD = {4{24'h87_0000}};
   localparam motor_cmd_type FULL_CMD  = {4{24'hFF_0000}};
   localparam motor_cmd_type NO_CMD    = '0;

   // fields from the top: y, x, height, yaw, pitch, roll
   localparam int NUM_DIRECTED = 22;
   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      {1'b1, HOVER_CMD, {Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO}},
      {1'b1, HOVER_CMD, {Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO}},
      // height error of one with all history zero drives every motor to the top
      {1'b1, FULL_CMD,  {Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}},
      {1'b0, NO_CMD,    {Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX}},
      {1'b0, NO_CMD,    {Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN}},
      {1'b0, NO_CMD,    {Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1}},
      {1'b0, NO_CMD,    {Q_ZERO, Q_MAX, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO}},
      {1'b0, NO_CMD,    {Q_ZERO, Q_MIN, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO}},
      {1'b0, NO_CMD,    {Q_MAX, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO}},
      {1'b0, NO_CMD,    {Q_MIN, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO}},
      {1'b0, NO_CMD,    {Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, Q_MAX}},
      {1'b0, NO_CMD,    {Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, Q_MIN}},
      {1'b0, NO_CMD,    {Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_MAX, Q_ZERO}},
      {1'b0, NO_CMD,    {Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_MIN, Q_ZERO}},
      {1'b0, NO_CMD,    {Q_ZERO, Q_ZERO, Q_ONE, Q_MAX, Q_ZERO, Q_ZERO}},
      {1'b0, NO_CMD,    {Q_ZERO, Q_ZERO, Q_ONE, Q_MIN, Q_ZERO, Q_ZERO}},
      {1'b0, NO_CMD,    {Q_ZERO, Q_ZERO, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO}},
      {1'b0, NO_CMD,    {Q_ZERO, Q_ZERO, Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO}},
      {1'b0, NO_CMD,    {{6{32'hAAAA_AAAA}}}},
      {1'b0, NO_CMD,    {{6{32'h5555_5555}}}},
      {1'b0, NO_CMD,    {32'h0000_0200, 32'hFFFF_FE00, 32'h0001_0064, 32'h0000_0100,
                         32'hFFFF_FFC0, 32'h0000_0040}},
      {1'b0, NO_CMD,    {Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO}}
   };

   localparam int NUM_PHASES = 6;
   localparam gain_set_type PHASE_GAINS [NUM_PHASES] = '{
      GAINS_DEFAULT, GAINS_RANDOM, GAINS_MAX, GAINS_ZERO, GAINS_MODEST, GAINS_DEFAULT
   };
   localparam int PHASE_ITEMS [NUM_PHASES] = '{300, 300, 200, 200, 300, 300};

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [191:0] req_tdata;   // roll, pitch, yaw, height, pos_x, pos_y (32 bits each)
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;   // motor_one, motor_two, motor_three, motor_four (24 bits each)
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [4:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   quadrotor_cascaded_pid_mixer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // controller copy: gains and loop history
   logic [31:0]        gain_reg [8];
   logic [31:0]        gain_default [8];
   logic signed [31:0] pos_sum [2];
   logic signed [31:0] pos_last [2];
   logic signed [31:0] ax_sum [4];
   logic signed [31:0] ax_last [4];
   logic signed [31:0] ax_last2 [4];

   motor_cmd_type motor_cmd_q [$];

   int errors = 0;
   int samples_sent = 0;
   int results_checked = 0;
   int gain_writes = 0;
   int send_idle_pct = 36;
   int recv_stall_pct = 56;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #10ms;
      $display("tb: failure");
      $finish;
   end

   function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return p[FB+31:FB];
   endfunction

   function automatic logic signed [31:0] clamp_to(input logic signed [31:0] v,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic void clear_history();
      for (int i = 0; i < 2; i++) begin
         pos_sum[i] = '0;
         pos_last[i] = '0;
      end
      for (int i = 0; i < 4; i++) begin
         ax_sum[i] = '0;
         ax_last[i] = '0;
         ax_last2[i] = '0;
      end
   endfunction

   // one controller step: outer position loop, inner loops, mixer
   function automatic motor_cmd_type run_cascade(input sensor_sample_type s);
      logic signed [31:0] ex, ey, dx, dy, u_r, u_p;
      logic signed [31:0] u_roll, u_pitch, u_yaw, u_lift;
      logic signed [31:0] err [4];
      logic signed [31:0] d1 [4];
      logic signed [31:0] d2 [4];
      logic signed [31:0] mix [4];
      logic signed [31:0] lim [4];
      motor_cmd_type m;
      ex = -s.pos_x;
      ey = -s.pos_y;
      pos_sum[0] = pos_sum[0] + ex;
      pos_sum[1] = pos_sum[1] + ey;
      dx = ex - pos_last[0];
      dy = ey - pos_last[1];
      pos_last[0] = ex;
      pos_last[1] = ey;

      u_r = qmul(-$signed(gain_reg[REG_POS_KD]), dy) - qmul($signed(gain_reg[REG_POS_KP]), ey)
            - qmul(POS_KI, pos_sum[1]);
      u_p = qmul($signed(gain_reg[REG_POS_KD]), dx) + qmul($signed(gain_reg[REG_POS_KP]), ex)
            + qmul(POS_KI, pos_sum[0]);
      u_r = clamp_to(u_r, -RAD_SAT, RAD_SAT);
      u_p = clamp_to(u_p, -RAD_SAT, RAD_SAT);

      err[0] = u_r - s.roll;
      err[1] = u_p - s.pitch;
      err[2] = -s.yaw;
      err[3] = $signed(Q_ONE) - s.height;
      for (int i = 0; i < 4; i++) begin
         ax_sum[i] = ax_sum[i] + err[i];
         d1[i] = err[i] - ax_last[i];
         d2[i] = err[i] - (ax_last[i] <<< 1) + ax_last2[i];
         ax_last2[i] = ax_last[i];
         ax_last[i] = err[i];
      end

      u_roll = qmul($signed(gain_reg[REG_ATT_KDD]), d2[0])
               + qmul($signed(gain_reg[REG_ATT_KD]), d1[0])
               + qmul($signed(gain_reg[REG_ATT_KP]), err[0]);
      u_pitch = qmul($signed(gain_reg[REG_ATT_KDD]), d2[1])
                + qmul($signed(gain_reg[REG_ATT_KD]), d1[1])
                + qmul($signed(gain_reg[REG_ATT_KP]), err[1]);
      u_yaw = d1[2] + err[2];
      u_lift = qmul(ALT_KDD, d2[3]) + qmul($signed(gain_reg[REG_ALT_KD]), d1[3])
               + qmul($signed(gain_reg[REG_ALT_KP]), err[3]) + qmul(ALT_KI, ax_sum[3])
               + $signed(gain_reg[REG_NOMINAL]);
      u_roll = clamp_to(u_roll, -U_SAT, U_SAT);
      u_pitch = clamp_to(u_pitch, -U_SAT, U_SAT);

      mix[0] = -u_pitch + u_yaw + u_lift;
      mix[1] = -u_roll - u_yaw + u_lift;
      mix[2] = u_pitch + u_yaw + u_lift;
      mix[3] = u_roll - u_yaw + u_lift;
      for (int i = 0; i < 4; i++) lim[i] = clamp_to(mix[i], 32'sd0, MOTOR_TOP);
      m.motor_one = lim[0][23:0];
      m.motor_two = lim[1][23:0];
      m.motor_three = lim[2][23:0];
      m.motor_four = lim[3][23:0];
      return m;
   endfunction

   function automatic logic [31:0] jitter(input int span);
      return 32'(int'($urandom_range(2 * span)) - span);
   endfunction

   function automatic logic [31:0] wild_word();
      logic [31:0] picks [4];
      picks = '{Q_MAX, Q_MIN, Q_ZERO, Q_NEG1};
      case ($urandom_range(3))
         0, 1:    return $urandom;
         2:       return picks[$urandom_range(3)];
         default: return jitter(1000);
      endcase
   endfunction

   // mostly near-hover flight with small errors, the rest arbitrary words
   function automatic sensor_sample_type rand_sample();
      sensor_sample_type s;
      if ($urandom_range(99) < 75) begin
         s.roll = jitter(400);
         s.pitch = jitter(400);
         s.yaw = jitter(3000);
         s.height = Q_ONE + jitter(400);
         s.pos_x = jitter(20000);
         s.pos_y = jitter(20000);
      end else begin
         s.roll = wild_word();
         s.pitch = wild_word();
         s.yaw = wild_word();
         s.height = wild_word();
         s.pos_x = wild_word();
         s.pos_y = wild_word();
      end
      return s;
   endfunction

   task automatic send_sample(input sensor_sample_type s, input logic typed,
                              input motor_cmd_type typed_cmd);
      motor_cmd_type predicted;
      if (samples_sent < 640) begin
         send_idle_pct = 36;
         recv_stall_pct = 56;
      end else if (samples_sent < 1280) begin
         send_idle_pct = 56;
         recv_stall_pct = 36;
      end else begin
         send_idle_pct = 0;
         recv_stall_pct = 0;
      end
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = run_cascade(s);
      motor_cmd_q.push_back(typed ? typed_cmd : predicted);
      samples_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (motor_cmd_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      logic [31:0] stored;
      stored = (idx == REG_NOMINAL) ? (value & 32'h00FF_FFFF) : (value & 32'h7FFF_FFFF);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      gain_reg[idx] = stored;
      gain_writes++;
      // read back the same register
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== stored) begin
         errors++;
         $display("%0t: register %0d readback expected %h actual %h",
                  $time, idx, stored, csr_prdata);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic load_gains(input gain_set_type kind);
      logic [2:0]  idx;
      logic [31:0] value;
      for (int i = 0; i < 8; i++) begin
         idx = 3'(i);
         case (kind)
            GAINS_RANDOM:
               value = (idx == REG_NOMINAL) ? 32'($urandom_range(32'hFF_0000)) : $urandom;
            GAINS_MAX:
               value = (idx == REG_NOMINAL) ? 32'h00FF_0000 : 32'hFFFF_FFFF;
            GAINS_ZERO:
               value = '0;
            GAINS_MODEST:
               value = (idx == REG_NOMINAL) ? 32'($urandom_range(32'hFF_0000))
                                            : 32'($urandom_range(20 * ONE));
            default:
               value = gain_default[idx];
         endcase
         csr_write(idx, value);
      end
   endtask

   task automatic check_field(input string name, input logic [23:0] want,
                              input logic [23:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      motor_cmd_type got;
      motor_cmd_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         results_checked++;
         if (motor_cmd_q.size() == 0) begin
            errors++;
            $display("%0t: motor result %h with no request outstanding", $time, got);
         end else begin
            want = motor_cmd_q.pop_front();
            check_field("motor_one", want.motor_one, got.motor_one);
            check_field("motor_two", want.motor_two, got.motor_two);
            check_field("motor_three", want.motor_three, got.motor_three);
            check_field("motor_four", want.motor_four, got.motor_four);
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;

      gain_default[REG_POS_KP] = 32'(ONE / 10);
      gain_default[REG_POS_KD] = 32'(5 * ONE / 2);
      gain_default[REG_ATT_KP] = 32'(10 * ONE);
      gain_default[REG_ATT_KD] = 32'(10 * ONE);
      gain_default[REG_ATT_KDD] = 32'(100 * ONE);
      gain_default[REG_ALT_KP] = 32'(10 * ONE);
      gain_default[REG_ALT_KD] = 32'(1000 * ONE);
      gain_default[REG_NOMINAL] = 32'(135 * ONE);
      gain_reg = gain_default;
      clear_history();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_sample(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].check,
                     DIRECTED_ROWS[i].motors);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            drain();
            load_gains(PHASE_GAINS[ph]);
         end
         repeat (PHASE_ITEMS[ph]) send_sample(rand_sample(), 1'b0, NO_CMD);
      end

      drain();
      repeat (40) @(posedge clock);

      $display("tb: %0d sensor samples over %0d gain sets, %0d register writes",
               samples_sent, NUM_PHASES, gain_writes);
      $display("tb: %0d motor results compared, %0d mismatches", results_checked, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
